>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Implication checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication checked at every edge, reset included.
`define ASSERT_NORST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/vtkd_pkg.sv
// Package: key codes, command codes, parse phases and step result type.
package vtkd_pkg;

  localparam int unsigned KEY_W   = 8;
  localparam int unsigned CMD_W   = 4;
  localparam int unsigned PHASE_W = 3;

  localparam logic [KEY_W-1:0] KEY_LBRACKET = 8'h5B;
  localparam logic [KEY_W-1:0] KEY_O        = 8'h4F;
  localparam logic [KEY_W-1:0] KEY_TILDE    = 8'h7E;
  localparam logic [KEY_W-1:0] KEY_A        = 8'h41;
  localparam logic [KEY_W-1:0] KEY_B        = 8'h42;
  localparam logic [KEY_W-1:0] KEY_H        = 8'h48;
  localparam logic [KEY_W-1:0] KEY_F        = 8'h46;
  localparam logic [KEY_W-1:0] KEY_P        = 8'h50;
  localparam logic [KEY_W-1:0] KEY_R        = 8'h52;
  localparam logic [KEY_W-1:0] KEY_S        = 8'h53;
  localparam logic [KEY_W-1:0] KEY_0        = 8'h30;
  localparam logic [KEY_W-1:0] KEY_1        = 8'h31;
  localparam logic [KEY_W-1:0] KEY_2        = 8'h32;
  localparam logic [KEY_W-1:0] KEY_5        = 8'h35;
  localparam logic [KEY_W-1:0] KEY_6        = 8'h36;
  localparam logic [KEY_W-1:0] KEY_9        = 8'h39;

  localparam logic [CMD_W-1:0] CMD_NONE   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_UP     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_DOWN   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_PGUP   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_PGDN   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_HOME   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_END    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_COPY   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DELETE = 4'd8;
  localparam logic [CMD_W-1:0] CMD_INSERT = 4'd9;
  localparam logic [CMD_W-1:0] CMD_HELP   = 4'd10;
  localparam logic [CMD_W-1:0] CMD_VIEW   = 4'd11;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 4'd12;
  localparam logic [CMD_W-1:0] CMD_EXIT   = 4'd13;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CSI     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SS3     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CSI1    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CSI2    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_TILDE   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_TILDE21 = 3'd6;
  localparam logic [PHASE_W-1:0] PH_SWALLOW = 3'd7;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [CMD_W-1:0]   pending;
    logic               emit;
    logic [CMD_W-1:0]   command;
  } vtkd_step_t;

endpackage

>>> rtl/vtkd_step.sv
// Next-state and result decode for one key byte.
module vtkd_step import vtkd_pkg::*; (
  input  logic [PHASE_W-1:0] phase,
  input  logic [CMD_W-1:0]   pending,
  input  logic [KEY_W-1:0]   key,
  input  logic               start,
  output vtkd_step_t         step
);

  // Sequence ends: back to idle with a result.
  function automatic vtkd_step_t done(input logic [CMD_W-1:0] cmd);
    vtkd_step_t s;
    s.phase   = PH_IDLE;
    s.pending = CMD_NONE;
    s.emit    = 1'b1;
    s.command = cmd;
    return s;
  endfunction

  function automatic vtkd_step_t go(input logic [PHASE_W-1:0] ph,
                                    input logic [CMD_W-1:0] pc);
    vtkd_step_t s;
    s.phase   = ph;
    s.pending = pc;
    s.emit    = 1'b0;
    s.command = CMD_NONE;
    return s;
  endfunction

  always_comb begin
    if (start) begin
      if (key == KEY_LBRACKET)  step = go(PH_CSI, CMD_NONE);
      else if (key == KEY_O)    step = go(PH_SS3, CMD_NONE);
      else                      step = done(CMD_NONE);
    end else begin
      case (phase)
        PH_CSI: begin
          if (key == KEY_A)       step = done(CMD_UP);
          else if (key == KEY_B)  step = done(CMD_DOWN);
          else if (key == KEY_5)  step = go(PH_TILDE, CMD_PGUP);
          else if (key == KEY_6)  step = go(PH_TILDE, CMD_PGDN);
          else if (key == KEY_H)  step = done(CMD_HOME);
          else if (key == KEY_F)  step = done(CMD_END);
          else if (key == KEY_1)  step = go(PH_CSI1, CMD_NONE);
          else if (key == KEY_2)  step = go(PH_CSI2, CMD_NONE);
          else                    step = done(CMD_NONE);
        end
        PH_SS3: begin
          if (key == KEY_P)       step = done(CMD_HELP);
          else if (key == KEY_R)  step = done(CMD_VIEW);
          else if (key == KEY_S)  step = done(CMD_DUMP);
          else                    step = done(CMD_NONE);
        end
        PH_CSI1: begin
          if (key == KEY_5)       step = go(PH_TILDE, CMD_COPY);
          else if (key == KEY_9)  step = go(PH_TILDE, CMD_DELETE);
          else if (key > KEY_5 && key < KEY_9) step = go(PH_SWALLOW, CMD_NONE);
          else                    step = done(CMD_NONE);
        end
        PH_CSI2: begin
          if (key == KEY_TILDE)   step = done(CMD_INSERT);
          else if (key == KEY_1)  step = go(PH_TILDE21, CMD_EXIT);
          else if (key >= KEY_0 && key <= KEY_9) step = go(PH_SWALLOW, CMD_NONE);
          else                    step = done(CMD_NONE);
        end
        PH_TILDE: begin
          step = done((key == KEY_TILDE) ? pending : CMD_NONE);
        end
        PH_TILDE21: begin
          if (key == KEY_TILDE)   step = done(pending);
          else                    step = go(PH_SWALLOW, CMD_NONE);
        end
        PH_SWALLOW: begin
          step = done(CMD_NONE);
        end
        default: begin
          // idle without a start flag: byte is dropped
          step = go(PH_IDLE, CMD_NONE);
        end
      endcase
    end
  end

endmodule

>>> rtl/vt100_key_sequence_decoder.sv
// Top level: VT100 key sequence decoder with input and result registers.
//
//  channel | dir | tdata (low bit up)           | tuser
//  in_     | in  | key_byte[7:0]                | first_after_escape
//  out_    | out | command[3:0], zeros [7:4]    | -
//
// One key byte per cycle unless a stalled result holds the input register.
// The input register feeds the decode logic, which updates the parse state and
// loads the result register in the same cycle. A stalled result holds only a
// byte that produces a result; bytes without a result pass regardless.
// Synchronous active-low reset clears both valid flags and the parse state.
module vt100_key_sequence_decoder import vtkd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // key_byte[7:0]
  input  logic         in_tuser,   // first_after_escape
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata   // command[3:0], zero padding [7:4]
);

  logic               in_valid_r;
  logic [KEY_W-1:0]   key_r;
  logic               start_r;
  logic [PHASE_W-1:0] phase_r;
  logic [CMD_W-1:0]   pend_r;
  logic               out_valid_r;
  logic [CMD_W-1:0]   cmd_r;

  logic               out_valid_nxt;
  logic               advance;
  vtkd_step_t         step;

  vtkd_step u_step (
    .phase   (phase_r),
    .pending (pend_r),
    .key     (key_r),
    .start   (start_r),
    .step    (step)
  );

  // held item moves on unless it has a result and the result slot is blocked
  assign advance   = in_valid_r && (!out_valid_r || out_tready || !step.emit);
  assign in_tready = rst_n && (!in_valid_r || advance);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && step.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      pend_r      <= CMD_NONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        phase_r <= step.phase;
        pend_r  <= step.pending;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r   <= in_tdata;
      start_r <= in_tuser;
    end
    if (advance && step.emit) begin
      cmd_r <= step.command;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - CMD_W){1'b0}}, cmd_r};

endmodule

>>> rtl/vtkd_checker.sv
// Port-level checker for the key sequence decoder, bound to the top level.
`include "assert_macros.svh"

module vtkd_checker import vtkd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  `ASSERT_IMPL(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_NORST(a_rst_clears, clk, !rst_n, !out_tvalid)
  `ASSERT_ALWAYS(a_pad_zero, clk, rst_n, !out_tvalid || out_tdata[7:4] == 4'd0)
  `ASSERT_ALWAYS(a_cmd_range, clk, rst_n, !out_tvalid || out_tdata[3:0] <= CMD_EXIT)

endmodule

bind vt100_key_sequence_decoder vtkd_checker u_vtkd_checker (.*);
